### rtl/ecr_pkg.sv
// ---------------------------------------------------------------------------
// ecr_pkg: shared types and constants of the elevation color ramp
// Height table, entry colors, segment spans and reciprocals, item types.
// ---------------------------------------------------------------------------
package ecr_pkg;

  localparam int TABLE_ENTRIES = 11;
  localparam int SEGS          = TABLE_ENTRIES - 1;
  localparam int IDX_W         = $clog2(TABLE_ENTRIES);
  localparam int CNT_W         = $clog2(TABLE_ENTRIES + 1);
  localparam int ELEV_W        = 16;
  localparam int CHAN_W        = 8;
  localparam int CHANNELS      = 3;
  // widest segment span is 4000, so the offset into a segment fits 12 bits
  localparam int DIST_W        = 12;
  // magnitude of delta times offset: below 255 * 4000
  localparam int NUM_W         = 20;
  // reciprocal scale; must be at least NUM_W so the estimate is off by one at most
  localparam int FRAC_BITS     = 20;
  localparam int RECIP_W       = 13;
  localparam int PROD_W        = NUM_W + RECIP_W;
  localparam int QUEUE_DEPTH   = 4;
  localparam int QPTR_W        = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W        = $clog2(QUEUE_DEPTH + 1);
  localparam int RGB_W         = CHANNELS * CHAN_W;

  localparam logic signed [ELEV_W-1:0] SEA_MARK = -16'sd9999;

  localparam logic signed [ELEV_W-1:0] HEIGHT [TABLE_ENTRIES] = '{
    -16'sd500, -16'sd250, 16'sd100, 16'sd300, 16'sd700, 16'sd1250,
    16'sd1750, 16'sd2500, 16'sd3500, 16'sd5000, 16'sd9000
  };

  // red, green, blue per entry
  localparam logic [CHAN_W-1:0] COLOR [TABLE_ENTRIES][CHANNELS] = '{
    '{8'h00, 8'ha0, 8'h00},
    '{8'h00, 8'hc0, 8'h00},
    '{8'h00, 8'hff, 8'h00},
    '{8'hc0, 8'hff, 8'h00},
    '{8'hff, 8'hff, 8'h00},
    '{8'hff, 8'hc0, 8'h00},
    '{8'hc0, 8'h80, 8'h00},
    '{8'ha0, 8'h70, 8'h00},
    '{8'h50, 8'h70, 8'hb0},
    '{8'h78, 8'ha8, 8'hd8},
    '{8'ha0, 8'he0, 8'hff}
  };

  localparam logic [CHAN_W-1:0] SEA_COLOR [CHANNELS] = '{8'h00, 8'h00, 8'hff};

  localparam logic [DIST_W-1:0] SPAN [SEGS] = '{
    DIST_W'(HEIGHT[1] - HEIGHT[0]),  DIST_W'(HEIGHT[2] - HEIGHT[1]),
    DIST_W'(HEIGHT[3] - HEIGHT[2]),  DIST_W'(HEIGHT[4] - HEIGHT[3]),
    DIST_W'(HEIGHT[5] - HEIGHT[4]),  DIST_W'(HEIGHT[6] - HEIGHT[5]),
    DIST_W'(HEIGHT[7] - HEIGHT[6]),  DIST_W'(HEIGHT[8] - HEIGHT[7]),
    DIST_W'(HEIGHT[9] - HEIGHT[8]),  DIST_W'(HEIGHT[10] - HEIGHT[9])
  };

  // floor(2^FRAC_BITS / span) per segment
  localparam logic [RECIP_W-1:0] RECIP [SEGS] = '{
    RECIP_W'((1 << FRAC_BITS) / SPAN[0]), RECIP_W'((1 << FRAC_BITS) / SPAN[1]),
    RECIP_W'((1 << FRAC_BITS) / SPAN[2]), RECIP_W'((1 << FRAC_BITS) / SPAN[3]),
    RECIP_W'((1 << FRAC_BITS) / SPAN[4]), RECIP_W'((1 << FRAC_BITS) / SPAN[5]),
    RECIP_W'((1 << FRAC_BITS) / SPAN[6]), RECIP_W'((1 << FRAC_BITS) / SPAN[7]),
    RECIP_W'((1 << FRAC_BITS) / SPAN[8]), RECIP_W'((1 << FRAC_BITS) / SPAN[9])
  };

  typedef enum logic [1:0] {
    KIND_SEA,
    KIND_FLAT,
    KIND_RAMP
  } kind_t;

  // classified sample: flat items use idx only, ramp items interpolate
  // from entry idx toward entry idx+1 at the given offset
  typedef struct packed {
    kind_t             kind;
    logic [IDX_W-1:0]  idx;
    logic [DIST_W-1:0] offset;
  } ramp_item_t;

endpackage

### rtl/ecr_front.sv
// ---------------------------------------------------------------------------
// ecr_front: sample classifier
// Accepts elevation samples and finds the table segment for each one.
// ---------------------------------------------------------------------------
module ecr_front (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           in_valid,
  output logic                           in_ready,
  input  logic signed [ecr_pkg::ELEV_W-1:0] in_elev,
  output logic                           out_valid,
  input  logic                           out_ready,
  output ecr_pkg::ramp_item_t            out_item
);

  logic [ecr_pkg::CNT_W-1:0]        cnt;
  logic [ecr_pkg::IDX_W-1:0]        lo;
  logic signed [ecr_pkg::ELEV_W:0]  diff;
  ecr_pkg::ramp_item_t              item_next;

  // count table heights at or below the sample
  always_comb begin
    cnt = '0;
    for (int i = 0; i < ecr_pkg::TABLE_ENTRIES; i++) begin
      if (in_elev >= ecr_pkg::HEIGHT[i]) begin
        cnt = ecr_pkg::CNT_W'(i + 1);
      end
    end
  end

  assign lo   = (cnt == '0) ? '0 : ecr_pkg::IDX_W'(cnt - 1'b1);
  assign diff = in_elev - ecr_pkg::HEIGHT[lo];

  // classify: sea, saturated or exact height, or interpolate
  always_comb begin
    item_next.kind   = ecr_pkg::KIND_FLAT;
    item_next.idx    = lo;
    item_next.offset = '0;
    priority if (in_elev == ecr_pkg::SEA_MARK) begin
      item_next.kind = ecr_pkg::KIND_SEA;
      item_next.idx  = '0;
    end else if (cnt == '0) begin
      item_next.idx = '0;
    end else if (cnt == ecr_pkg::CNT_W'(ecr_pkg::TABLE_ENTRIES)) begin
      item_next.idx = ecr_pkg::IDX_W'(ecr_pkg::TABLE_ENTRIES - 1);
    end else if (diff == '0) begin
      item_next.idx = lo;
    end else begin
      item_next.kind   = ecr_pkg::KIND_RAMP;
      item_next.offset = ecr_pkg::DIST_W'(diff);
    end
  end

  assign in_ready = !out_valid || out_ready;

  // hold the classified item until the queue takes it
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (in_ready) begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      out_item <= item_next;
    end
  end

endmodule

### rtl/ecr_queue.sv
// ---------------------------------------------------------------------------
// ecr_queue: item queue between classifier and interpolator
// Small register FIFO so either side can stall on its own.
// ---------------------------------------------------------------------------
module ecr_queue (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_ready,
  input  ecr_pkg::ramp_item_t in_item,
  output logic                out_valid,
  input  logic                out_ready,
  output ecr_pkg::ramp_item_t out_item
);

  ecr_pkg::ramp_item_t          slots [ecr_pkg::QUEUE_DEPTH];
  logic [ecr_pkg::QPTR_W-1:0]   wr_ptr;
  logic [ecr_pkg::QPTR_W-1:0]   rd_ptr;
  logic [ecr_pkg::QCNT_W-1:0]   count;
  logic                         push;
  logic                         pop;

  assign in_ready  = (count != ecr_pkg::QCNT_W'(ecr_pkg::QUEUE_DEPTH));
  assign out_valid = (count != '0);
  assign push      = in_valid && in_ready;
  assign pop       = out_valid && out_ready;
  assign out_item  = slots[rd_ptr];

  // advance pointers and occupancy
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      unique case ({push, pop})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= in_item;
    end
  end

endmodule

### rtl/ecr_back.sv
// ---------------------------------------------------------------------------
// ecr_back: channel interpolator
// Four-stage pipeline: delta times offset, reciprocal multiply, estimate
// times span, then remainder check and signed add onto the base color into
// the output register.
// ---------------------------------------------------------------------------
module ecr_back (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  ecr_pkg::ramp_item_t         in_item,
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic [ecr_pkg::CHAN_W-1:0]  red,
  output logic [ecr_pkg::CHAN_W-1:0]  green,
  output logic [ecr_pkg::CHAN_W-1:0]  blue
);

  logic en;
  logic v1, v2, v3;

  // stage 1 combinational lookups
  logic [ecr_pkg::IDX_W-1:0]  hi_idx;
  logic [ecr_pkg::IDX_W-1:0]  seg;
  logic [ecr_pkg::CHAN_W-1:0] c0 [ecr_pkg::CHANNELS];
  logic [ecr_pkg::CHAN_W-1:0] c1 [ecr_pkg::CHANNELS];
  logic [ecr_pkg::CHAN_W-1:0] mag [ecr_pkg::CHANNELS];

  // stage registers
  logic                         ramp1, ramp2, ramp3;
  logic [ecr_pkg::CHAN_W-1:0]   base1 [ecr_pkg::CHANNELS];
  logic [ecr_pkg::CHAN_W-1:0]   base2 [ecr_pkg::CHANNELS];
  logic [ecr_pkg::CHAN_W-1:0]   base3 [ecr_pkg::CHANNELS];
  logic                         neg1 [ecr_pkg::CHANNELS];
  logic                         neg2 [ecr_pkg::CHANNELS];
  logic                         neg3 [ecr_pkg::CHANNELS];
  logic [ecr_pkg::NUM_W-1:0]    num1 [ecr_pkg::CHANNELS];
  logic [ecr_pkg::NUM_W-1:0]    num2 [ecr_pkg::CHANNELS];
  logic [ecr_pkg::NUM_W-1:0]    num3 [ecr_pkg::CHANNELS];
  logic [ecr_pkg::DIST_W-1:0]   span1, span2, span3;
  logic [ecr_pkg::RECIP_W-1:0]  recip1;
  logic [ecr_pkg::PROD_W-1:0]   est2 [ecr_pkg::CHANNELS];
  logic [ecr_pkg::CHAN_W-1:0]   quo3 [ecr_pkg::CHANNELS];
  logic [ecr_pkg::NUM_W-1:0]    back3 [ecr_pkg::CHANNELS];

  // final stage combinational
  logic [ecr_pkg::NUM_W-1:0]    rem [ecr_pkg::CHANNELS];
  logic [ecr_pkg::CHAN_W:0]     quo [ecr_pkg::CHANNELS];
  logic signed [ecr_pkg::CHAN_W+1:0] sum [ecr_pkg::CHANNELS];
  logic [ecr_pkg::CHAN_W-1:0]   chan_next [ecr_pkg::CHANNELS];

  // whole pipeline advances when the output register is free
  assign en       = !out_valid || out_ready;
  assign in_ready = en;

  // look up the segment ends and the channel deltas
  always_comb begin
    hi_idx = (in_item.idx == ecr_pkg::IDX_W'(ecr_pkg::TABLE_ENTRIES - 1)) ?
             in_item.idx : in_item.idx + 1'b1;
    seg    = (in_item.idx >= ecr_pkg::IDX_W'(ecr_pkg::SEGS)) ?
             ecr_pkg::IDX_W'(ecr_pkg::SEGS - 1) : in_item.idx;
    for (int c = 0; c < ecr_pkg::CHANNELS; c++) begin
      c0[c]  = ecr_pkg::COLOR[in_item.idx][c];
      c1[c]  = ecr_pkg::COLOR[hi_idx][c];
      mag[c] = (c1[c] >= c0[c]) ? c1[c] - c0[c] : c0[c] - c1[c];
    end
  end

  // recover the exact quotient from the estimate and apply the sign
  always_comb begin
    for (int c = 0; c < ecr_pkg::CHANNELS; c++) begin
      rem[c] = num3[c] - back3[c];
      quo[c] = {1'b0, quo3[c]} +
               (ecr_pkg::CHAN_W+1)'(rem[c] >= ecr_pkg::NUM_W'(span3));
      sum[c] = neg3[c] ? $signed({2'b00, base3[c]}) - $signed({1'b0, quo[c]})
                       : $signed({2'b00, base3[c]}) + $signed({1'b0, quo[c]});
      priority if (!ramp3) begin
        chan_next[c] = base3[c];
      end else if (sum[c] < 0) begin
        chan_next[c] = '0;
      end else if (sum[c] > $signed(10'd255)) begin
        chan_next[c] = '1;
      end else begin
        chan_next[c] = sum[c][ecr_pkg::CHAN_W-1:0];
      end
    end
  end

  // stage valid bits
  always_ff @(posedge clk) begin
    if (rst) begin
      v1        <= 1'b0;
      v2        <= 1'b0;
      v3        <= 1'b0;
      out_valid <= 1'b0;
    end else if (en) begin
      v1        <= in_valid;
      v2        <= v1;
      v3        <= v2;
      out_valid <= v3;
    end
  end

  // stage payloads
  always_ff @(posedge clk) begin
    if (en) begin
      ramp1  <= (in_item.kind == ecr_pkg::KIND_RAMP);
      span1  <= ecr_pkg::SPAN[seg];
      recip1 <= ecr_pkg::RECIP[seg];
      ramp2  <= ramp1;
      span2  <= span1;
      ramp3  <= ramp2;
      span3  <= span2;
      for (int c = 0; c < ecr_pkg::CHANNELS; c++) begin
        base1[c] <= (in_item.kind == ecr_pkg::KIND_SEA) ? ecr_pkg::SEA_COLOR[c] : c0[c];
        neg1[c]  <= (c1[c] < c0[c]);
        num1[c]  <= ecr_pkg::NUM_W'(mag[c]) * ecr_pkg::NUM_W'(in_item.offset);
        base2[c] <= base1[c];
        neg2[c]  <= neg1[c];
        num2[c]  <= num1[c];
        est2[c]  <= ecr_pkg::PROD_W'(num1[c]) * ecr_pkg::PROD_W'(recip1);
        base3[c] <= base2[c];
        neg3[c]  <= neg2[c];
        num3[c]  <= num2[c];
        quo3[c]  <= est2[c][ecr_pkg::FRAC_BITS +: ecr_pkg::CHAN_W];
        back3[c] <= ecr_pkg::NUM_W'(est2[c][ecr_pkg::FRAC_BITS +: ecr_pkg::CHAN_W]) *
                    ecr_pkg::NUM_W'(span2);
      end
      red   <= chan_next[0];
      green <= chan_next[1];
      blue  <= chan_next[2];
    end
  end

endmodule

### rtl/elevation_color_ramp.sv
// Throughput: one sample per cycle, one pixel per cycle while the output is not stalled, set by the four-stage
// interpolator whose stages all advance whenever the output register is free.
// A four-entry queue lets the classifier keep accepting while the output stalls, until the queue is full.
// Reset (rst, synchronous, active high) empties the queue and all valid bits.
// ---------------------------------------------------------------------------
// elevation_color_ramp: hypsometric tint color map
// Maps a signed elevation sample to an RGB pixel by piecewise-linear ramp.
// ---------------------------------------------------------------------------
module elevation_color_ramp (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [15:0] s_tdata,   // [15:0] elevation
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [23:0] m_tdata    // [7:0] red, [15:8] green, [23:16] blue
);

  logic                 f_valid;
  logic                 f_ready;
  ecr_pkg::ramp_item_t  f_item;
  logic                 q_valid;
  logic                 q_ready;
  ecr_pkg::ramp_item_t  q_item;
  logic [ecr_pkg::CHAN_W-1:0] red;
  logic [ecr_pkg::CHAN_W-1:0] green;
  logic [ecr_pkg::CHAN_W-1:0] blue;

  ecr_front u_front (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (s_tvalid),
    .in_ready  (s_tready),
    .in_elev   ($signed(s_tdata)),
    .out_valid (f_valid),
    .out_ready (f_ready),
    .out_item  (f_item)
  );

  ecr_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (f_valid),
    .in_ready  (f_ready),
    .in_item   (f_item),
    .out_valid (q_valid),
    .out_ready (q_ready),
    .out_item  (q_item)
  );

  ecr_back u_back (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (q_valid),
    .in_ready  (q_ready),
    .in_item   (q_item),
    .out_valid (m_tvalid),
    .out_ready (m_tready),
    .red       (red),
    .green     (green),
    .blue      (blue)
  );

  assign m_tdata = {blue, green, red};

`ifndef SYNTH
  // a sea sample is classified as sea
  a_sea_class: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready && (s_tdata == ecr_pkg::SEA_MARK) |=>
      f_valid && (f_item.kind == ecr_pkg::KIND_SEA))
    else $error("sea sample not classified as sea");

  // interpolated items always name a segment with a following entry
  a_ramp_seg: assert property (@(posedge clk) disable iff (rst)
    q_valid && (q_item.kind == ecr_pkg::KIND_RAMP) |->
      (q_item.idx < ecr_pkg::IDX_W'(ecr_pkg::SEGS)) && (q_item.offset != '0))
    else $error("ramp item outside the table");

  // no pixel is shown right after reset
  a_reset_empty: assert property (@(posedge clk)
    rst |=> !m_tvalid)
    else $error("output valid after reset");
`endif

endmodule

### tb/elevation_color_ramp_tb.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// elevation_color_ramp_tb: self-checking bench for the elevation color ramp
// Streams signed height samples through the ramp, predicts each RGB pixel
// from a local copy of the height/color table and compares every pixel
// channel by channel, with random gaps on the input and stalls on the output.
// ---------------------------------------------------------------------------
module elevation_color_ramp_tb;

  localparam int N_ENTRIES    = 11;
  localparam int SEA_HEIGHT   = -9999;
  localparam int CH_RED       = 0;
  localparam int CH_GREEN     = 1;
  localparam int CH_BLUE      = 2;
  localparam int CYCLE_LIMIT  = 200000;
  localparam int DRAIN_CYCLES = 12;

  // representative heights and their red, green, blue tints
  localparam int TINT_HEIGHT [N_ENTRIES] = '{
    -500, -250, 100, 300, 700, 1250, 1750, 2500, 3500, 5000, 9000
  };
  localparam int TINT_RGB [N_ENTRIES][3] = '{
    '{8'h00, 8'ha0, 8'h00},
    '{8'h00, 8'hc0, 8'h00},
    '{8'h00, 8'hff, 8'h00},
    '{8'hc0, 8'hff, 8'h00},
    '{8'hff, 8'hff, 8'h00},
    '{8'hff, 8'hc0, 8'h00},
    '{8'hc0, 8'h80, 8'h00},
    '{8'ha0, 8'h70, 8'h00},
    '{8'h50, 8'h70, 8'hb0},
    '{8'h78, 8'ha8, 8'hd8},
    '{8'ha0, 8'he0, 8'hff}
  };

  typedef struct {
    logic signed [15:0] elev;
    logic [7:0]         red;
    logic [7:0]         green;
    logic [7:0]         blue;
  } pixel_t;

  logic        clk      = 1'b0;
  logic        rst      = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [15:0] s_tdata  = '0;   // [15:0] elevation
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [23:0] m_tdata;         // [7:0] red, [15:8] green, [23:16] blue

  pixel_t pending_pixels [$];
  bit     idle_en = 1'b1;
  int     mismatches = 0;
  int     samples_sent = 0;
  int     pixels_checked = 0;
  int     sea_sent = 0;
  int     clamped_sent = 0;
  int     cycles = 0;
  int     stall_left = 0;

  elevation_color_ramp dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
  );

  always #2 clk = ~clk;

  // abort on a hung run
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d pixels outstanding", cycles,
               pending_pixels.size());
      $display("elevation_color_ramp_tb: FAIL");
      $finish;
    end
  end

  // tint of one height sample, interpolated per channel
  function automatic pixel_t tint_for(input logic signed [15:0] elev);
    int     e;
    int     lo;
    int     hi;
    int     v;
    bit     have_lo;
    bit     have_hi;
    int     chan [3];
    pixel_t px;
    e       = elev;
    lo      = 0;
    hi      = 0;
    have_lo = 1'b0;
    have_hi = 1'b0;
    px.elev = elev;
    if (e == SEA_HEIGHT) begin
      px.red   = 8'h00;
      px.green = 8'h00;
      px.blue  = 8'hff;
      return px;
    end
    for (int i = 0; i < N_ENTRIES; i++) begin
      if (TINT_HEIGHT[i] <= e) begin
        lo      = i;
        have_lo = 1'b1;
      end
      if (e <= TINT_HEIGHT[i] && !have_hi) begin
        hi      = i;
        have_hi = 1'b1;
      end
    end
    // saturate outside the table
    if (!have_lo) lo = hi;
    if (!have_hi) hi = lo;
    for (int c = 0; c < 3; c++) begin
      if (lo == hi) begin
        v = TINT_RGB[lo][c];
      end else begin
        // signed int division truncates toward zero
        v = TINT_RGB[lo][c] + (TINT_RGB[hi][c] - TINT_RGB[lo][c]) *
            (e - TINT_HEIGHT[lo]) / (TINT_HEIGHT[hi] - TINT_HEIGHT[lo]);
      end
      if (v < 0) v = 0;
      if (v > 255) v = 255;
      chan[c] = v;
    end
    px.red   = chan[CH_RED][7:0];
    px.green = chan[CH_GREEN][7:0];
    px.blue  = chan[CH_BLUE][7:0];
    return px;
  endfunction

  task automatic report_mismatch(input string field, input logic signed [15:0] elev,
                                 input logic [7:0] got, input logic [7:0] want);
    $display("[%0t] mismatch on %s for elevation %0d: got 0x%02h, expected 0x%02h",
             $time, field, elev, got, want);
    mismatches++;
  endtask

  // hold off the output at random, in short bursts
  always @(posedge clk) begin
    if (stall_left > 0) begin
      m_tready <= 1'b0;
      stall_left = stall_left - 1;
    end else if (idle_en && $urandom_range(0, 4) == 0) begin
      m_tready <= 1'b0;
      stall_left = $urandom_range(1, 3) - 1;
    end else begin
      m_tready <= 1'b1;
    end
  end

  // compare each delivered pixel with the oldest prediction
  always @(posedge clk) begin
    pixel_t want;
    if (!rst && m_tvalid && m_tready) begin
      if (pending_pixels.size() == 0) begin
        $display("[%0t] unexpected pixel 0x%06h with no sample outstanding",
                 $time, m_tdata);
        mismatches++;
      end else begin
        want = pending_pixels.pop_front();
        if (m_tdata[7:0] !== want.red)
          report_mismatch("red", want.elev, m_tdata[7:0], want.red);
        if (m_tdata[15:8] !== want.green)
          report_mismatch("green", want.elev, m_tdata[15:8], want.green);
        if (m_tdata[23:16] !== want.blue)
          report_mismatch("blue", want.elev, m_tdata[23:16], want.blue);
        pixels_checked++;
      end
    end
  end

  // offer one sample, wait for the handshake, queue its predicted pixel
  task automatic send_sample(input logic signed [15:0] elev);
    if (idle_en && $urandom_range(0, 3) == 0) begin
      s_tvalid <= 1'b0;
      repeat ($urandom_range(1, 3)) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= elev;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    pending_pixels.push_back(tint_for(elev));
    samples_sent++;
    if (elev == SEA_HEIGHT) sea_sent++;
    else if (elev < TINT_HEIGHT[0] || elev > TINT_HEIGHT[N_ENTRIES-1]) clamped_sent++;
  endtask

  // a height spread over all table segments, sometimes within two of an entry
  function automatic logic signed [15:0] ramp_height();
    int seg;
    seg = $urandom_range(0, N_ENTRIES - 2);
    if ($urandom_range(0, 4) == 0)
      return 16'(TINT_HEIGHT[seg] + $urandom_range(0, 4) - 2);
    return 16'($urandom_range(TINT_HEIGHT[seg + 1] - TINT_HEIGHT[seg]) + TINT_HEIGHT[seg]);
  endfunction

  task automatic test_sea_marker();
    send_sample(16'(SEA_HEIGHT));
    send_sample(16'(SEA_HEIGHT - 1));
    send_sample(16'(SEA_HEIGHT + 1));
    send_sample(16'(SEA_HEIGHT));
  endtask

  task automatic test_saturation();
    send_sample(16'sh8000);
    send_sample(-16'sd501);
    send_sample(16'sd9001);
    send_sample(16'sh7fff);
  endtask

  task automatic test_table_heights();
    for (int i = 0; i < N_ENTRIES; i++) send_sample(16'(TINT_HEIGHT[i]));
  endtask

  task automatic test_interpolation_points();
    send_sample(16'sd0);
    send_sample(-16'sd1);
    send_sample(16'sd1);
    send_sample(-16'sd499);
    send_sample(16'sd4999);
    send_sample(16'sd8999);
  endtask

  task automatic test_random_ramp(input int count);
    for (int n = 0; n < count; n++) begin
      if ($urandom_range(0, 19) == 0) send_sample(16'(SEA_HEIGHT));
      else send_sample(ramp_height());
    end
  endtask

  task automatic test_random_full_range(input int count);
    for (int n = 0; n < count; n++) send_sample(16'($urandom));
  endtask

  task automatic test_back_to_back(input int count);
    idle_en = 1'b0;
    for (int n = 0; n < count; n++) begin
      case ($urandom_range(0, 5))
        0:       send_sample(16'($urandom));
        1:       send_sample(16'(SEA_HEIGHT));
        default: send_sample(ramp_height());
      endcase
    end
  endtask

  initial begin
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_sea_marker();
    test_saturation();
    test_table_heights();
    test_interpolation_points();
    test_random_ramp(400);
    test_random_full_range(100);
    test_back_to_back(100);

    s_tvalid <= 1'b0;
    while (pending_pixels.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("sent %0d samples (%0d sea markers, %0d outside the table), checked %0d pixels",
             samples_sent, sea_sent, clamped_sent, pixels_checked);
    $display("mismatches: %0d", mismatches);
    if (mismatches == 0 && pending_pixels.size() == 0) begin
      $display("elevation_color_ramp_tb: PASS");
    end else begin
      $display("elevation_color_ramp_tb: FAIL");
    end
    $finish;
  end

endmodule

### sim.f
rtl/ecr_pkg.sv
rtl/ecr_front.sv
rtl/ecr_queue.sv
rtl/ecr_back.sv
rtl/elevation_color_ramp.sv
tb/elevation_color_ramp_tb.sv
